// File: src/dq_pkg.sv
// Shared types and constants for the double-ended queue.
// Holds request codes, status codes and field widths; no dependencies.
package dq_pkg;

  // Field widths of the request and result items.
  localparam int unsigned ReqW    = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  // Packed width of the result payload, padded to whole bytes.
  localparam int unsigned OutFieldsW = DataW + StatusW + CountW + 1;
  localparam int unsigned OutTdataW  = ((OutFieldsW + 7) / 8) * 8;

  // Default number of ring slots.
  localparam int unsigned DefDepth = 16;

  // Value returned by a pop or peek on an empty queue.
  localparam logic [DataW-1:0] DataEmpty = '1;

  // Request codes; the two codes above peek back change no state and return zero data.
  typedef enum logic [ReqW-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5
  } req_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

// File: src/dq_ram.sv
// Slot store of the double-ended queue: one write port and one read port.
// Read data is registered and appears in the cycle after the read enable.
// Depends on dq_pkg for the data width.
module dq_ram #(
  parameter int unsigned Depth = dq_pkg::DefDepth,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [dq_pkg::DataW-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [dq_pkg::DataW-1:0] rdata_o
);

  logic [dq_pkg::DataW-1:0] mem [Depth];
  logic [dq_pkg::DataW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/double_ended_queue.sv
// Double-ended queue of unsigned 32-bit values kept in a ring of RAM slots.
// A result item appears in the cycle after its request item is accepted.
// Throughput: one request item per cycle; the single RAM port pair and the
// output register set it, and a stalled result holds the next request back.
// Reset: pointers and count clear to zero; slot contents are not cleared.
module double_ended_queue #(
  parameter int unsigned DEPTH = dq_pkg::DefDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request items.
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [dq_pkg::DataW-1:0]     s_axis_tdata_i,  // [31:0] value
  input  logic [dq_pkg::ReqW-1:0]      s_axis_tuser_i,  // [2:0] req_type
  // Result items.
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [31:0] data, [33:32] status, [38:34] count, [39] is_empty
  output logic [dq_pkg::OutTdataW-1:0] m_axis_tdata_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  // Control state.
  logic [PtrW-1:0] front_q, front_d;
  logic [PtrW-1:0] back_q, back_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q;

  // Result payload registers.
  logic [dq_pkg::DataW-1:0]   data_q, data_d;
  dq_pkg::status_e            status_q, status_d;
  logic [dq_pkg::CountW-1:0]  count_q;
  logic                       empty_q;
  logic                       use_rd_q, use_rd_d;

  // RAM access for the accepted request.
  logic                     we, re;
  logic [PtrW-1:0]          waddr, raddr;
  logic [dq_pkg::DataW-1:0] rdata;

  logic            s_fire;
  logic            q_full, q_empty;
  logic [PtrW-1:0] front_inc, front_dec, back_inc, back_dec;
  dq_pkg::req_e    req;
  logic [CntW+dq_pkg::CountW-1:0] cnt_ext;

  // A request is taken when the output register is free or being emptied.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  assign q_full  = (cnt_q == CntFull);
  assign q_empty = (cnt_q == '0);
  assign req     = dq_pkg::req_e'(s_axis_tuser_i);

  // Ring pointer neighbors, wrapping at DEPTH.
  assign front_inc = (front_q == PtrLast) ? '0 : front_q + PtrW'(1);
  assign front_dec = (front_q == '0) ? PtrLast : front_q - PtrW'(1);
  assign back_inc  = (back_q == PtrLast) ? '0 : back_q + PtrW'(1);
  assign back_dec  = (back_q == '0) ? PtrLast : back_q - PtrW'(1);

  // Decode the request into pointer updates, RAM accesses and result fields.
  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    cnt_d    = cnt_q;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = back_q;
    raddr    = front_q;
    data_d   = '0;
    status_d = dq_pkg::ST_OK;
    use_rd_d = 1'b0;
    case (req)
      dq_pkg::REQ_PUSH_BACK: begin
        data_d = s_axis_tdata_i;
        if (q_full) begin
          status_d = dq_pkg::ST_FULL;
        end else begin
          we     = 1'b1;
          waddr  = back_q;
          back_d = back_inc;
          cnt_d  = cnt_q + CntW'(1);
        end
      end
      dq_pkg::REQ_PUSH_FRONT: begin
        data_d = s_axis_tdata_i;
        if (q_full) begin
          status_d = dq_pkg::ST_FULL;
        end else begin
          we      = 1'b1;
          waddr   = front_dec;
          front_d = front_dec;
          cnt_d   = cnt_q + CntW'(1);
        end
      end
      dq_pkg::REQ_POP_FRONT, dq_pkg::REQ_PEEK_FRONT: begin
        if (q_empty) begin
          data_d   = dq_pkg::DataEmpty;
          status_d = dq_pkg::ST_EMPTY;
        end else begin
          re       = 1'b1;
          raddr    = front_q;
          use_rd_d = 1'b1;
          if (req == dq_pkg::REQ_POP_FRONT) begin
            front_d = front_inc;
            cnt_d   = cnt_q - CntW'(1);
          end
        end
      end
      dq_pkg::REQ_POP_BACK, dq_pkg::REQ_PEEK_BACK: begin
        if (q_empty) begin
          data_d   = dq_pkg::DataEmpty;
          status_d = dq_pkg::ST_EMPTY;
        end else begin
          re       = 1'b1;
          raddr    = back_dec;
          use_rd_d = 1'b1;
          if (req == dq_pkg::REQ_POP_BACK) begin
            back_d = back_dec;
            cnt_d  = cnt_q - CntW'(1);
          end
        end
      end
      default: begin
        data_d = '0;
      end
    endcase
  end

  // Slot store.
  dq_ram #(
    .Depth (DEPTH),
    .AddrW (PtrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we && s_fire),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata_i),
    .re_i    (re && s_fire),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Pointer, count and output-valid state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      back_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_fire) begin
        front_q <= front_d;
        back_q  <= back_d;
        cnt_q   <= cnt_d;
      end
      if (s_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The reported count is the low bits of the entry count.
  assign cnt_ext = {{dq_pkg::CountW{1'b0}}, cnt_d};

  // Result payload, loaded with each accepted request.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      data_q   <= data_d;
      status_q <= status_d;
      count_q  <= cnt_ext[dq_pkg::CountW-1:0];
      empty_q  <= (cnt_d == '0);
      use_rd_q <= use_rd_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = dq_pkg::OutTdataW'({empty_q, count_q, status_q,
                                               (use_rd_q ? rdata : data_q)});

`ifndef SYNTH
  // The entry count never runs past the ring size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("entry count exceeds ring size");

  // A request never writes and reads the store at once.
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && re))
    else $error("write and read issued for one request");

  // Every accepted request leaves a result in the output register.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> out_valid_q)
    else $error("accepted request produced no result");

  // A pop on an empty queue reports empty and leaves the count at zero.
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && q_empty && (req == dq_pkg::REQ_POP_FRONT ||
                           req == dq_pkg::REQ_POP_BACK))
    |=> (status_q == dq_pkg::ST_EMPTY && cnt_q == '0))
    else $error("empty pop not reported as empty");
`endif

endmodule
